@@ rtl/tpli_pkg.sv @@
// Shared widths, codes and limits for the track and plane intersection pipeline.
package tpli_pkg;

    // Lane count (x, y, z)
    localparam int LANES = 3;

    // Datapath widths
    localparam int COORD_W = 32;              // Q15.16 coordinate
    localparam int D_W     = COORD_W + 1;     // start minus origin
    localparam int DN_W    = D_W + COORD_W;   // one term of n.(p - o)
    localparam int VN_W    = 2 * COORD_W;     // one term of n.v
    localparam int NUM_W   = DN_W + 2;        // n.(p - o)
    localparam int DEN_W   = VN_W + 2;        // n.v
    localparam int LO_SPLIT = 34;             // low slice of the numerator
    localparam int HI_W    = NUM_W - LO_SPLIT;
    localparam int PHI_W   = HI_W + COORD_W;
    localparam int PLO_W   = LO_SPLIT + 1 + COORD_W;
    localparam int NP_W    = NUM_W + COORD_W; // numerator times direction
    localparam int NMAG_W  = NP_W - 1;
    localparam int DMAG_W  = DEN_W;
    localparam int QB      = 49;              // quotient bits resolved by the divider
    localparam int QMAG_W  = QB + 1;
    localparam int Q_W     = 48;              // clamped local offset
    localparam int V_W     = QMAG_W + 2;      // offset before clamping

    // Divider latency: load stage, one stage per quotient bit, rounding stage
    localparam int DIV_LAT = QB + 2;

    // Rotation mixer
    localparam int K_W       = 33;            // Q1.30 coefficient, negation included
    localparam int X_W       = 52;
    localparam int SPLIT     = 26;
    localparam int ROT_SHIFT = 30;
    localparam int ROT_LAT   = 2;

    localparam logic signed [Q_W-1:0] Q_LIMIT = 48'sh7fff_ffff_ffff;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_PARALLEL = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_NORMAL_A = 3'd0;
    localparam logic [2:0] CFG_NORMAL_B = 3'd1;
    localparam logic [2:0] CFG_NORMAL_C = 3'd2;
    localparam logic [2:0] CFG_ORIGIN_X = 3'd3;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd4;
    localparam logic [2:0] CFG_ORIGIN_Z = 3'd5;
    localparam logic [2:0] CFG_ROT_X    = 3'd6;
    localparam logic [2:0] CFG_ROT_Y    = 3'd7;

endpackage

@@ rtl/tpli_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, rounded to nearest.
module tpli_div
    import tpli_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [NMAG_W-1:0] num_mag,
    input  logic [DMAG_W-1:0] den_mag,
    output logic [QMAG_W-1:0] quot_mag,
    output logic              ovf
);

    logic [DMAG_W-1:0] rem_reg [0:QB];
    logic [QB-1:0]     low_reg [0:QB];
    logic [QB-1:0]     quo_reg [0:QB];
    logic [DMAG_W-1:0] den_reg [0:QB];
    logic              ovf_reg [0:QB];
    logic [QMAG_W-1:0] quot_reg;
    logic              ovf_out_reg;
    logic [DMAG_W-1:0] top_part;

    // Upper numerator bits form the first partial remainder
    assign top_part = {{(DMAG_W - (NMAG_W - QB)){1'b0}}, num_mag[NMAG_W-1:QB]};

    // Load: a quotient of 2^QB or more is flagged as overflow
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= top_part;
            low_reg[0] <= num_mag[QB-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den_mag;
            ovf_reg[0] <= (top_part >= den_mag);
        end
    end

    // One quotient bit per stage
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [DMAG_W:0]   shifted;
        logic [DMAG_W+1:0] diff;

        assign shifted = {rem_reg[k-1], low_reg[k-1][QB-1]};
        assign diff    = {1'b0, shifted} - {2'b00, den_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!diff[DMAG_W+1])
                begin
                    rem_reg[k] <= diff[DMAG_W-1:0];
                    quo_reg[k] <= {quo_reg[k-1][QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= shifted[DMAG_W-1:0];
                    quo_reg[k] <= {quo_reg[k-1][QB-2:0], 1'b0};
                end
                low_reg[k] <= {low_reg[k-1][QB-2:0], 1'b0};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    // Round to nearest, ties away from zero
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= {1'b0, quo_reg[QB]} +
                        QMAG_W'({rem_reg[QB], 1'b0} >= {1'b0, den_reg[QB]});
            ovf_out_reg <= ovf_reg[QB];
        end
    end

    assign quot_mag = quot_reg;
    assign ovf      = ovf_out_reg;

endmodule

@@ rtl/tpli_rot.sv @@
// Two-stage rotation mixer: round((k1*x + k2*y) / 2^30) with split products.
module tpli_rot
    import tpli_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [K_W-1:0] k1,
    input  logic signed [K_W-1:0] k2,
    input  logic signed [X_W-1:0] x,
    input  logic signed [X_W-1:0] y,
    output logic signed [X_W-1:0] r
);

    localparam int PH_W = K_W + X_W - SPLIT;
    localparam int PL_W = K_W + SPLIT + 1;
    localparam int S_W  = K_W + X_W + 1;

    logic signed [PH_W-1:0] ph1_reg, ph2_reg;
    logic signed [PL_W-1:0] pl1_reg, pl2_reg;
    logic signed [X_W-1:0]  r_reg;
    logic signed [S_W-1:0]  hi_sum;
    logic signed [S_W-1:0]  s;

    // Partial products on the high and low slices
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph1_reg <= k1 * $signed(x[X_W-1:SPLIT]);
            ph2_reg <= k2 * $signed(y[X_W-1:SPLIT]);
            pl1_reg <= k1 * $signed({1'b0, x[SPLIT-1:0]});
            pl2_reg <= k2 * $signed({1'b0, y[SPLIT-1:0]});
        end
    end

    // Combine, add half an LSB and drop the fraction
    assign hi_sum = S_W'(ph1_reg) + S_W'(ph2_reg);
    assign s      = (hi_sum <<< SPLIT) + S_W'(pl1_reg) + S_W'(pl2_reg)
                    + (S_W'(1) <<< (ROT_SHIFT - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= s[ROT_SHIFT+X_W-1:ROT_SHIFT];
        end
    end

    assign r = r_reg;

endmodule

@@ rtl/track_plane_local_intersect_core.sv @@
// Top level: track and plane intersection with transform to plane-local coordinates.
//
// Each transaction on the slave side carries a straight track (start point and
// direction) or, with tuser set, a global point; the block returns one
// transaction of local coordinates per input. Mode 0 intersects the track with
// the plane n.(x - o) = 0; both modes then subtract the origin and apply the
// inverse Y and X rotations. All values are Q15.16, rotation terms Q1.30. A
// track with n.v == 0 returns zeros with status parallel; a clamped or
// saturated result returns status saturated. The pipeline takes one
// transaction per cycle unless the master side stalls, and passes it through 63
// register stages; 51 of those stages are the restoring divider, which resolves
// one quotient bit per stage.
// A stall on the master side freezes the whole pipeline and holds s_tready
// low. Write configuration only while the pipeline is empty.
module track_plane_local_intersect_core
    import tpli_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // slave stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // start_x, dir_x, start_y, dir_y, start_z, dir_z
    input  logic         s_tuser,   // mode
    // master stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // local_x, local_y, local_z
    output logic [1:0]   m_tuser,   // status
    // configuration
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    typedef struct packed {
        logic                        valid;
        logic                        mode;
        logic                        par;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][D_W-1:0]   d;
    } div_side_t;

    typedef struct packed {
        logic                        valid;
        logic                        par;
        logic                        sat;
        logic [X_W-1:0]              keep;
    } rot_side_t;

    // Configuration registers
    logic signed [COORD_W-1:0] normal_reg [LANES];
    logic signed [COORD_W-1:0] origin_reg [LANES];
    logic [63:0]               rot_x_reg, rot_y_reg;

    logic en;

    // Stage registers
    logic                      v1_reg, mode1_reg;
    logic signed [D_W-1:0]     d1_reg [LANES];
    logic signed [COORD_W-1:0] dir1_reg [LANES];

    logic                      v2_reg, mode2_reg;
    logic signed [D_W-1:0]     d2_reg [LANES];
    logic signed [COORD_W-1:0] dir2_reg [LANES];
    logic signed [DN_W-1:0]    dn2_reg [LANES];
    logic signed [VN_W-1:0]    vn2_reg [LANES];

    logic                      v3_reg, mode3_reg;
    logic signed [D_W-1:0]     d3_reg [LANES];
    logic signed [COORD_W-1:0] dir3_reg [LANES];
    logic signed [NUM_W-1:0]   num3_reg;
    logic signed [DEN_W-1:0]   den3_reg;

    logic                      v4_reg, mode4_reg, par4_reg;
    logic signed [D_W-1:0]     d4_reg [LANES];
    logic signed [DEN_W-1:0]   den4_reg;
    logic signed [PHI_W-1:0]   phi4_reg [LANES];
    logic signed [PLO_W-1:0]   plo4_reg [LANES];

    logic                      v5_reg, mode5_reg, par5_reg;
    logic signed [D_W-1:0]     d5_reg [LANES];
    logic signed [DEN_W-1:0]   den5_reg;
    logic signed [NP_W-1:0]    np5_reg [LANES];

    logic                      v6_reg, mode6_reg, par6_reg;
    logic signed [D_W-1:0]     d6_reg [LANES];
    logic [LANES-1:0]          neg6_reg;
    logic [NMAG_W-1:0]         nmag6_reg [LANES];
    logic [DMAG_W-1:0]         dmag6_reg;

    div_side_t                 div_side_reg [DIV_LAT];
    logic [QMAG_W-1:0]         quot_mag [LANES];
    logic [LANES-1:0]          quot_ovf;

    logic                      v7_reg, par7_reg, sat7_reg;
    logic signed [Q_W-1:0]     q7_reg [LANES];
    logic signed [Q_W-1:0]     q_next [LANES];
    logic [LANES-1:0]          clamp_next;

    rot_side_t                 rot1_side_reg [ROT_LAT];
    rot_side_t                 rot2_side_reg [ROT_LAT];
    logic signed [X_W-1:0]     ux, uz, ly, lz;

    logic                      m_valid_reg;
    logic [95:0]               m_data_reg;
    logic [1:0]                m_status_reg;

    logic signed [K_W-1:0]     cx, sx, cy, sy, nsx, nsy;
    logic signed [X_W-1:0]     q0_ext, q1_ext, q2_ext;
    logic [COORD_W-1:0]        out_next [LANES];
    logic [LANES-1:0]          osat_next;
    logic signed [X_W-1:0]     lval [LANES];

    // Advance the whole pipeline unless a result is held at the output
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg[0] <= '0;
            normal_reg[1] <= '0;
            normal_reg[2] <= 32'sh0001_0000;
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            origin_reg[2] <= '0;
            rot_x_reg     <= 64'h4000_0000_0000_0000;
            rot_y_reg     <= 64'h4000_0000_0000_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NORMAL_A: normal_reg[0] <= cfg_data[31:0];
                CFG_NORMAL_B: normal_reg[1] <= cfg_data[31:0];
                CFG_NORMAL_C: normal_reg[2] <= cfg_data[31:0];
                CFG_ORIGIN_X: origin_reg[0] <= cfg_data[31:0];
                CFG_ORIGIN_Y: origin_reg[1] <= cfg_data[31:0];
                CFG_ORIGIN_Z: origin_reg[2] <= cfg_data[31:0];
                CFG_ROT_X:    rot_x_reg     <= cfg_data;
                CFG_ROT_Y:    rot_y_reg     <= cfg_data;
                default:      rot_y_reg     <= rot_y_reg;
            endcase
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg      <= s_tvalid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            v6_reg      <= v5_reg;
            v7_reg      <= div_side_reg[DIV_LAT-1].valid;
            m_valid_reg <= rot2_side_reg[ROT_LAT-1].valid;
        end
    end

    // Stages 1 to 6: offsets, dot products, numerator times direction, magnitudes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode1_reg <= s_tuser;
            mode2_reg <= mode1_reg;
            mode3_reg <= mode2_reg;
            mode4_reg <= mode3_reg;
            mode5_reg <= mode4_reg;
            mode6_reg <= mode5_reg;
            for (int i = 0; i < LANES; i++)
            begin
                d1_reg[i]   <= D_W'($signed(s_tdata[64*i +: COORD_W]))
                               - D_W'(origin_reg[i]);
                dir1_reg[i] <= $signed(s_tdata[64*i+COORD_W +: COORD_W]);
                d2_reg[i]   <= d1_reg[i];
                dir2_reg[i] <= dir1_reg[i];
                dn2_reg[i]  <= d1_reg[i] * normal_reg[i];
                vn2_reg[i]  <= dir1_reg[i] * normal_reg[i];
                d3_reg[i]   <= d2_reg[i];
                dir3_reg[i] <= dir2_reg[i];
                d4_reg[i]   <= d3_reg[i];
                phi4_reg[i] <= $signed(num3_reg[NUM_W-1:LO_SPLIT]) * dir3_reg[i];
                plo4_reg[i] <= $signed({1'b0, num3_reg[LO_SPLIT-1:0]}) * dir3_reg[i];
                d5_reg[i]   <= d4_reg[i];
                np5_reg[i]  <= (NP_W'(phi4_reg[i]) <<< LO_SPLIT) + NP_W'(plo4_reg[i]);
                d6_reg[i]   <= d5_reg[i];
                neg6_reg[i] <= np5_reg[i][NP_W-1] ^ den5_reg[DEN_W-1];
                nmag6_reg[i] <= np5_reg[i][NP_W-1] ? NMAG_W'(-np5_reg[i])
                                                   : NMAG_W'(np5_reg[i]);
            end
            num3_reg  <= NUM_W'(dn2_reg[0]) + NUM_W'(dn2_reg[1]) + NUM_W'(dn2_reg[2]);
            den3_reg  <= DEN_W'(vn2_reg[0]) + DEN_W'(vn2_reg[1]) + DEN_W'(vn2_reg[2]);
            den4_reg  <= den3_reg;
            par4_reg  <= !mode3_reg && (den3_reg == '0);
            den5_reg  <= den4_reg;
            par5_reg  <= par4_reg;
            par6_reg  <= par5_reg;
            dmag6_reg <= den5_reg[DEN_W-1] ? DMAG_W'(-den5_reg) : DMAG_W'(den5_reg);
        end
    end

    // Dividers, one per lane
    for (genvar i = 0; i < LANES; i++)
    begin : g_div
        tpli_div u_div (
            .clk      (clk),
            .en       (en),
            .num_mag  (nmag6_reg[i]),
            .den_mag  (dmag6_reg),
            .quot_mag (quot_mag[i]),
            .ovf      (quot_ovf[i])
        );
    end

    // Carry the offsets and flags alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_LAT; k++)
            begin
                div_side_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            div_side_reg[0].valid <= v6_reg;
            div_side_reg[0].mode  <= mode6_reg;
            div_side_reg[0].par   <= par6_reg;
            div_side_reg[0].neg   <= neg6_reg;
            for (int i = 0; i < LANES; i++)
            begin
                div_side_reg[0].d[i] <= d6_reg[i];
            end
            for (int k = 1; k < DIV_LAT; k++)
            begin
                div_side_reg[k] <= div_side_reg[k-1];
            end
        end
    end

    // Stage 7: in mode 0 subtract the track term and clamp; mode 1 passes the offset
    always_comb
    begin
        logic signed [V_W-1:0] quot_s;
        logic signed [V_W-1:0] diff;
        logic signed [D_W-1:0] dval;
        for (int i = 0; i < LANES; i++)
        begin
            dval   = $signed(div_side_reg[DIV_LAT-1].d[i]);
            quot_s = div_side_reg[DIV_LAT-1].neg[i] ? -$signed({2'b00, quot_mag[i]})
                                                    : $signed({2'b00, quot_mag[i]});
            diff   = V_W'(dval) - quot_s;
            clamp_next[i] = 1'b0;
            if (div_side_reg[DIV_LAT-1].mode)
            begin
                q_next[i] = Q_W'(dval);
            end
            else if (quot_ovf[i])
            begin
                q_next[i]     = div_side_reg[DIV_LAT-1].neg[i] ? Q_LIMIT : -Q_LIMIT;
                clamp_next[i] = 1'b1;
            end
            else if (diff > V_W'(Q_LIMIT))
            begin
                q_next[i]     = Q_LIMIT;
                clamp_next[i] = 1'b1;
            end
            else if (diff < -V_W'(Q_LIMIT))
            begin
                q_next[i]     = -Q_LIMIT;
                clamp_next[i] = 1'b1;
            end
            else
            begin
                q_next[i] = diff[Q_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                q7_reg[i] <= q_next[i];
            end
            par7_reg <= div_side_reg[DIV_LAT-1].par;
            sat7_reg <= |clamp_next;
        end
    end

    // Rotation coefficients
    assign cx  = K_W'($signed(rot_x_reg[63:32]));
    assign sx  = K_W'($signed(rot_x_reg[31:0]));
    assign cy  = K_W'($signed(rot_y_reg[63:32]));
    assign sy  = K_W'($signed(rot_y_reg[31:0]));
    assign nsx = -sx;
    assign nsy = -sy;

    assign q0_ext = X_W'(q7_reg[0]);
    assign q1_ext = X_W'(q7_reg[1]);
    assign q2_ext = X_W'(q7_reg[2]);

    // Inverse rotation about y
    tpli_rot u_rot_ux (.clk(clk), .en(en), .k1(cy),  .k2(sy), .x(q0_ext), .y(q2_ext), .r(ux));
    tpli_rot u_rot_uz (.clk(clk), .en(en), .k1(nsy), .k2(cy), .x(q0_ext), .y(q2_ext), .r(uz));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROT_LAT; k++)
            begin
                rot1_side_reg[k] <= '0;
                rot2_side_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            rot1_side_reg[0].valid <= v7_reg;
            rot1_side_reg[0].par   <= par7_reg;
            rot1_side_reg[0].sat   <= sat7_reg;
            rot1_side_reg[0].keep  <= q1_ext;
            rot1_side_reg[1]       <= rot1_side_reg[0];
            rot2_side_reg[0].valid <= rot1_side_reg[1].valid;
            rot2_side_reg[0].par   <= rot1_side_reg[1].par;
            rot2_side_reg[0].sat   <= rot1_side_reg[1].sat;
            rot2_side_reg[0].keep  <= ux;
            rot2_side_reg[1]       <= rot2_side_reg[0];
        end
    end

    // Inverse rotation about x
    tpli_rot u_rot_ly (
        .clk(clk), .en(en), .k1(cx), .k2(nsx),
        .x($signed(rot1_side_reg[1].keep)), .y(uz), .r(ly)
    );
    tpli_rot u_rot_lz (
        .clk(clk), .en(en), .k1(sx), .k2(cx),
        .x($signed(rot1_side_reg[1].keep)), .y(uz), .r(lz)
    );

    // Saturate to 32 bits
    assign lval[0] = $signed(rot2_side_reg[ROT_LAT-1].keep);
    assign lval[1] = ly;
    assign lval[2] = lz;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            osat_next[i] = 1'b0;
            if (lval[i] > X_W'(32'sh7fff_ffff))
            begin
                out_next[i]  = 32'h7fff_ffff;
                osat_next[i] = 1'b1;
            end
            else if (lval[i] < -X_W'(33'sh0_8000_0000))
            begin
                out_next[i]  = 32'h8000_0000;
                osat_next[i] = 1'b1;
            end
            else
            begin
                out_next[i] = lval[i][COORD_W-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rot2_side_reg[ROT_LAT-1].par)
            begin
                m_data_reg   <= '0;
                m_status_reg <= ST_PARALLEL;
            end
            else
            begin
                m_data_reg   <= {out_next[2], out_next[1], out_next[0]};
                m_status_reg <= (rot2_side_reg[ROT_LAT-1].sat || (|osat_next))
                                ? ST_SAT : ST_OK;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_status_reg;

endmodule
